### rtl/apct_pkg.sv
// Shared types, widths and helpers for the AABB pair contact tracker.
`timescale 1ns / 1ps
package apct_pkg;

	localparam int ID_W            = 6;
	localparam int COORD_W         = 32;
	localparam int SIZE_W          = 31;
	localparam int EXT_W           = 34;
	localparam int MAX_OBJECTS_DEF = 64;
	localparam int MIDQ_DEPTH      = 2;
	localparam int OUTQ_DEPTH      = 4;

	typedef logic signed [EXT_W-1:0] ext_t;

	typedef struct packed {
		logic            ov;
		logic            pair_ok;
		logic [ID_W-1:0] id_lo;
		logic [ID_W-1:0] id_hi;
	} pair_t;

	typedef struct packed {
		logic contact_enter;
		logic overlapping;
	} result_t;

	function automatic ext_t span_lo(input logic [COORD_W-1:0] c, input logic [SIZE_W-1:0] s);
		return {c[COORD_W-1], c, 1'b0} - {{(EXT_W-SIZE_W){1'b0}}, s};
	endfunction

	function automatic ext_t span_hi(input logic [COORD_W-1:0] c, input logic [SIZE_W-1:0] s);
		return {c[COORD_W-1], c, 1'b0} + {{(EXT_W-SIZE_W){1'b0}}, s};
	endfunction

endpackage

### rtl/apct_fifo.sv
// Small register queue with occupancy count.
`timescale 1ns / 1ps
module apct_fifo #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [WIDTH-1:0]             wr_data,
	output logic                         full,
	input  logic                         rd_en,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/apct_front.sv
// Front end: register the box pair, form doubled spans, test overlap, classify the id pair.
`timescale 1ns / 1ps
module apct_front #(
	parameter int MAX_OBJECTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic [apct_pkg::ID_W-1:0]       id_a,
	input  logic [apct_pkg::ID_W-1:0]       id_b,
	input  logic signed [apct_pkg::COORD_W-1:0] a_center_x,
	input  logic signed [apct_pkg::COORD_W-1:0] a_center_y,
	input  logic [apct_pkg::SIZE_W-1:0]     a_size_x,
	input  logic [apct_pkg::SIZE_W-1:0]     a_size_y,
	input  logic signed [apct_pkg::COORD_W-1:0] b_center_x,
	input  logic signed [apct_pkg::COORD_W-1:0] b_center_y,
	input  logic [apct_pkg::SIZE_W-1:0]     b_size_x,
	input  logic [apct_pkg::SIZE_W-1:0]     b_size_y,
	output logic                            stall,
	input  logic                            mid_full,
	output logic                            mid_push,
	output apct_pkg::pair_t                 mid_data
);
	import apct_pkg::*;

	localparam int MAX_BITS = $clog2(MAX_OBJECTS + 1);
	localparam int CMP_W    = (MAX_BITS > ID_W) ? MAX_BITS : ID_W;
	localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_OBJECTS);

	logic               v_s1;
	logic [ID_W-1:0]    id_a_s1, id_b_s1;
	logic [COORD_W-1:0] acx_s1, acy_s1, bcx_s1, bcy_s1;
	logic [SIZE_W-1:0]  asx_s1, asy_s1, bsx_s1, bsy_s1;

	logic               v_s2;
	logic               ok_s2;
	logic [ID_W-1:0]    lo_s2, hi_s2;
	ext_t               ax_lo_s2, ax_hi_s2, bx_lo_s2, bx_hi_s2;
	ext_t               ay_lo_s2, ay_hi_s2, by_lo_s2, by_hi_s2;

	logic               s1_adv, s2_adv;
	logic               pair_ok;
	logic               a_first;
	logic               ov;

	assign s2_adv   = !v_s2 || !mid_full;
	assign s1_adv   = !v_s1 || s2_adv;
	assign stall    = !s1_adv;
	assign mid_push = v_s2 && !mid_full;

	assign pair_ok = (id_a_s1 != id_b_s1) && (CMP_W'(id_a_s1) < MAX_C)
		&& (CMP_W'(id_b_s1) < MAX_C);
	assign a_first = id_a_s1 < id_b_s1;

	assign ov = (ax_lo_s2 <= bx_hi_s2) && (bx_lo_s2 <= ax_hi_s2)
		&& (ay_lo_s2 <= by_hi_s2) && (by_lo_s2 <= ay_hi_s2);

	assign mid_data = '{ov: ov, pair_ok: ok_s2, id_lo: lo_s2, id_hi: hi_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_adv) begin
				v_s1 <= take;
			end
			if (s2_adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && take) begin
			id_a_s1 <= id_a;
			id_b_s1 <= id_b;
			acx_s1  <= a_center_x;
			acy_s1  <= a_center_y;
			asx_s1  <= a_size_x;
			asy_s1  <= a_size_y;
			bcx_s1  <= b_center_x;
			bcy_s1  <= b_center_y;
			bsx_s1  <= b_size_x;
			bsy_s1  <= b_size_y;
		end
		if (s2_adv && v_s1) begin
			ok_s2    <= pair_ok;
			lo_s2    <= a_first ? id_a_s1 : id_b_s1;
			hi_s2    <= a_first ? id_b_s1 : id_a_s1;
			ax_lo_s2 <= span_lo(acx_s1, asx_s1);
			ax_hi_s2 <= span_hi(acx_s1, asx_s1);
			bx_lo_s2 <= span_lo(bcx_s1, bsx_s1);
			bx_hi_s2 <= span_hi(bcx_s1, bsx_s1);
			ay_lo_s2 <= span_lo(acy_s1, asy_s1);
			ay_hi_s2 <= span_hi(acy_s1, asy_s1);
			by_lo_s2 <= span_lo(bcy_s1, bsy_s1);
			by_hi_s2 <= span_hi(bcy_s1, bsy_s1);
		end
	end

endmodule

### rtl/apct_back.sv
// Back end: contact bitmap memory, read-modify-write with bypass, result generation.
`timescale 1ns / 1ps
module apct_back #(
	parameter int MAX_OBJECTS = 64
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        mid_empty,
	input  apct_pkg::pair_t                             mid_data,
	output logic                                        mid_pop,
	input  logic [$clog2(apct_pkg::OUTQ_DEPTH+1)-1:0]   outq_count,
	output logic                                        res_push,
	output apct_pkg::result_t                           res_data,
	output logic                                        clearing
);
	import apct_pkg::*;

	localparam int PAIR_DEPTH = MAX_OBJECTS * MAX_OBJECTS;
	localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
	localparam int CNT_W      = $clog2(OUTQ_DEPTH + 1);
	localparam logic [PAIR_AW-1:0] MAX_A  = PAIR_AW'(MAX_OBJECTS);
	localparam logic [PAIR_AW-1:0] LAST_A = PAIR_AW'(PAIR_DEPTH - 1);

	logic               pair_mem_q [PAIR_DEPTH];
	logic               clr_busy_q;
	logic [PAIR_AW-1:0] clr_addr_q;

	logic               v_s2;
	pair_t              entry_s2;
	logic [PAIR_AW-1:0] addr_s2;
	logic               rd_bit_s2;

	logic               lastw_v_q;
	logic [PAIR_AW-1:0] lastw_addr_q;
	logic               lastw_bit_q;

	logic               issue;
	logic [PAIR_AW-1:0] rd_addr;
	logic               was;
	logic               wr_en;

	assign issue = !mid_empty && !clr_busy_q
		&& ((CNT_W+1)'(outq_count) + (CNT_W+1)'(v_s2) + (CNT_W+1)'(1)
			<= (CNT_W+1)'(OUTQ_DEPTH));
	assign mid_pop  = issue;
	assign rd_addr  = PAIR_AW'(mid_data.id_lo) * MAX_A + PAIR_AW'(mid_data.id_hi);
	assign clearing = clr_busy_q;

	assign was   = (lastw_v_q && (lastw_addr_q == addr_s2)) ? lastw_bit_q : rd_bit_s2;
	assign wr_en = v_s2 && entry_s2.pair_ok;

	assign res_push = v_s2;
	assign res_data = '{contact_enter: entry_s2.pair_ok && entry_s2.ov && !was,
		overlapping: entry_s2.ov};

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			pair_mem_q[clr_addr_q] <= 1'b0;
		end else if (wr_en) begin
			pair_mem_q[addr_s2] <= entry_s2.ov;
		end
		if (issue) begin
			rd_bit_s2 <= pair_mem_q[rd_addr];
			entry_s2  <= mid_data;
			addr_s2   <= rd_addr;
		end
		if (wr_en) begin
			lastw_addr_q <= addr_s2;
			lastw_bit_q  <= entry_s2.ov;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			v_s2       <= 1'b0;
			lastw_v_q  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				if (clr_addr_q == LAST_A) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			v_s2      <= issue;
			lastw_v_q <= wr_en;
		end
	end

endmodule

### rtl/aabb_pair_contact_tracker.sv
// Top level of the AABB pair contact tracker.
`timescale 1ns / 1ps
// Tests two axis-aligned boxes per beat for closed-interval overlap on both axes and tracks
// which object pairs are in contact, flagging contact_enter when a pair starts to overlap.
// After reset the block sweeps its contact bitmap clear, one entry per clock, over all
// MAX_OBJECTS*MAX_OBJECTS entries with full held high. After that it takes one beat per
// clock while results drain and full stays low, set by the bitmap memory (one read port,
// one write port) whose read-modify-write is pipelined with a one-entry write bypass.
// The front end and the bitmap back end are joined by a two-entry queue, and results wait
// in a four-entry queue, so either side may stall without losing beats.
module aabb_pair_contact_tracker #(
	parameter int MAX_OBJECTS = apct_pkg::MAX_OBJECTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [apct_pkg::ID_W-1:0]           id_a,
	input  logic [apct_pkg::ID_W-1:0]           id_b,
	input  logic signed [apct_pkg::COORD_W-1:0] a_center_x,
	input  logic signed [apct_pkg::COORD_W-1:0] a_center_y,
	input  logic [apct_pkg::SIZE_W-1:0]         a_size_x,
	input  logic [apct_pkg::SIZE_W-1:0]         a_size_y,
	input  logic signed [apct_pkg::COORD_W-1:0] b_center_x,
	input  logic signed [apct_pkg::COORD_W-1:0] b_center_y,
	input  logic [apct_pkg::SIZE_W-1:0]         b_size_x,
	input  logic [apct_pkg::SIZE_W-1:0]         b_size_y,
	output logic                                empty,
	input  logic                                pop,
	output logic                                contact_enter,
	output logic                                overlapping
);
	import apct_pkg::*;

	logic                              front_stall;
	logic                              clearing;
	logic                              take;
	logic                              mid_push;
	logic                              mid_pop;
	logic                              mid_full;
	logic                              mid_empty;
	pair_t                             mid_wdata;
	pair_t                             mid_rdata;
	logic                              res_push;
	result_t                           res_data;
	result_t                           res_head;
	logic [$clog2(OUTQ_DEPTH+1)-1:0]   outq_count;

	assign full          = clearing || front_stall;
	assign take          = push && !full;
	assign contact_enter = res_head.contact_enter;
	assign overlapping   = res_head.overlapping;

	apct_front #(
		.MAX_OBJECTS(MAX_OBJECTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.id_a       (id_a),
		.id_b       (id_b),
		.a_center_x (a_center_x),
		.a_center_y (a_center_y),
		.a_size_x   (a_size_x),
		.a_size_y   (a_size_y),
		.b_center_x (b_center_x),
		.b_center_y (b_center_y),
		.b_size_x   (b_size_x),
		.b_size_y   (b_size_y),
		.stall      (front_stall),
		.mid_full   (mid_full),
		.mid_push   (mid_push),
		.mid_data   (mid_wdata)
	);

	apct_fifo #(
		.WIDTH($bits(pair_t)),
		.DEPTH(MIDQ_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wdata),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_rdata),
		.empty   (mid_empty),
		.count   ()
	);

	apct_back #(
		.MAX_OBJECTS(MAX_OBJECTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mid_empty  (mid_empty),
		.mid_data   (mid_rdata),
		.mid_pop    (mid_pop),
		.outq_count (outq_count),
		.res_push   (res_push),
		.res_data   (res_data),
		.clearing   (clearing)
	);

	apct_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUTQ_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.full    (),
		.rd_en   (pop),
		.rd_data (res_head),
		.empty   (empty),
		.count   (outq_count)
	);

endmodule
